// ----- src/plt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the peer liveness table.
// Used by plt_cell and peer_liveness_table_top; depends on nothing else.
package plt_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned AgeW   = 16;
  localparam int unsigned CountW = 7;

  localparam logic [AgeW-1:0] AgeMax       = '1;
  localparam logic [AgeW-1:0] StaleLimRst  = 16'd5000;

  // Operation broadcast to every cell in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_BEAT  = 2'd1,
    OP_TICK  = 2'd2,
    OP_SWEEP = 2'd3
  } plt_op_e;

  typedef struct packed {
    plt_op_e          op;
    logic [AddrW-1:0] addr;
    logic [AgeW-1:0]  stale_limit;
  } plt_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [AgeW-1:0]  age;
  } plt_entry_t;

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] peer_address;
  } plt_in_t;

  typedef struct packed {
    logic              hit;
    logic              inserted;
    logic              dropped_full;
    logic [CountW-1:0] purged_count;
    logic [CountW-1:0] live_count;
  } plt_out_t;

endpackage

// ----- src/plt_cell.sv -----
`timescale 1ns / 1ps
// One table cell: holds an address, its age and a valid bit, and a purge flag.
// Depends on plt_pkg; instantiated as a row in peer_liveness_table_top.
module plt_cell import plt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  plt_ctrl_t  ctrl_i,
  input  logic       insert_sel_i,
  input  plt_entry_t nxt_i,
  input  logic       prv_valid_i,
  input  logic       nxt_flag_i,
  output plt_entry_t entry_o,
  output logic       hit_o,
  output logic       flag_o
);

  logic             valid_q, valid_d;
  logic             flag_q, flag_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AgeW-1:0]  age_q, age_d;
  logic [AgeW-1:0]  age_inc;

  assign hit_o   = valid_q && (addr_q == ctrl_i.addr);
  assign age_inc = (age_q == AgeMax) ? age_q : age_q + AgeW'(1);

  always_comb begin
    valid_d = valid_q;
    flag_d  = flag_q;
    addr_d  = addr_q;
    age_d   = age_q;
    unique case (ctrl_i.op)
      OP_BEAT: begin
        if (hit_o) begin
          age_d = '0;
        end else if (insert_sel_i) begin
          valid_d = 1'b1;
          addr_d  = ctrl_i.addr;
          age_d   = '0;
        end
      end
      OP_TICK: begin
        flag_d = 1'b0;
        if (valid_q) begin
          age_d = age_inc;
          if (age_inc >= ctrl_i.stale_limit) begin
            valid_d = 1'b0;
            flag_d  = 1'b1;
          end
        end
      end
      OP_SWEEP: begin
        // Purge flags drain towards cell 0; holes bubble towards the far end.
        flag_d = nxt_flag_i;
        if (!valid_q && nxt_i.valid) begin
          valid_d = 1'b1;
          addr_d  = nxt_i.addr;
          age_d   = nxt_i.age;
        end else if (valid_q && !prv_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    age_q  <= age_d;
  end

  assign entry_o = '{valid: valid_q, addr: addr_q, age: age_q};
  assign flag_o  = flag_q;

endmodule

// ----- src/peer_liveness_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the peer liveness table: handshakes, APB register, control and cell row.
// Depends on plt_pkg and plt_cell.
//
//   Channel   Direction  Handshake                     Word
//   in        input      in_valid_i / in_ready_o       plt_in_t  (cmd, peer_address)
//   out       output     out_valid_o / out_ready_i     plt_out_t (flags and counts)
//   apb       input      psel, penable, pwrite, pready stale_limit at byte address 0
//
// A heartbeat: all cells compare the address in parallel and update at the accept edge,
// and the result is registered, then copied to the output register once that is free.
// A tick: ages update at the accept edge, then purge flags shift one cell per cycle to a
// counter at cell 0 while the row compacts; the sweep ends once every flag is counted and the row is compact.
// Reset clears all valid bits at once; there is no clearing pass.
// One word is worked on at a time; a new word is taken while a result waits at the output.
module peer_liveness_table_top import plt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  plt_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output plt_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   purge_q, purge_d;
  logic [SW-1:0]   sweep_cnt_q, sweep_cnt_d;
  logic [AgeW-1:0] stale_q;
  plt_out_t        res_q, res_d;
  plt_out_t        out_q;
  logic            out_valid_q;

  plt_ctrl_t       ctrl;
  plt_entry_t      entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec, valid_vec, flag_vec, insert_sel;
  logic            in_hs, beat, tick, any_hit, full, do_insert, gap;
  logic            sweep_last, sweep_end, out_load;
  logic [CW-1:0]   purge_sum;

  // Configuration port. Byte offsets within a word are not decoded.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, stale_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= StaleLimRst;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      stale_q <= pwdata[AgeW-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_hs      = in_valid_i && in_ready_o;
  assign beat       = in_hs && !in_data_i.cmd;
  assign tick       = in_hs && in_data_i.cmd;

  assign any_hit    = |hit_vec;
  assign full       = (count_q == CW'(TABLE_DEPTH));
  assign do_insert  = beat && !any_hit && !full;

  always_comb begin
    ctrl.addr        = in_data_i.peer_address;
    ctrl.stale_limit = stale_q;
    if (beat) begin
      ctrl.op = OP_BEAT;
    end else if (tick) begin
      ctrl.op = OP_TICK;
    end else if (state_q == ST_SWEEP) begin
      ctrl.op = OP_SWEEP;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    plt_entry_t nxt;
    logic       prv_valid;
    logic       nxt_flag;

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt      = '0;
      assign nxt_flag = 1'b0;
    end else begin : g_mid
      assign nxt      = entry_w[i+1];
      assign nxt_flag = flag_vec[i+1];
    end

    if (i == 0) begin : g_first
      assign prv_valid = 1'b1;
    end else begin : g_rest
      assign prv_valid = entry_w[i-1].valid;
    end

    // The row is kept compact, so the first free slot is at index count_q.
    assign insert_sel[i] = do_insert && (count_q == CW'(i));
    assign valid_vec[i]  = entry_w[i].valid;

    plt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .insert_sel_i (insert_sel[i]),
      .nxt_i        (nxt),
      .prv_valid_i  (prv_valid),
      .nxt_flag_i   (nxt_flag),
      .entry_o      (entry_w[i]),
      .hit_o        (hit_vec[i]),
      .flag_o       (flag_vec[i])
    );
  end

  // A hole followed by a valid entry means the row is not yet compact.
  assign gap = |(~valid_vec[TABLE_DEPTH-2:0] & valid_vec[TABLE_DEPTH-1:1]);

  assign sweep_last = (sweep_cnt_q == SW'(TABLE_DEPTH - 1));
  assign sweep_end  = (state_q == ST_SWEEP) && sweep_last && !gap;
  assign purge_sum  = purge_q + CW'(flag_vec[0]);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    purge_d     = purge_q;
    sweep_cnt_d = sweep_cnt_q;
    res_d       = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (beat) begin
          res_d.hit          = any_hit;
          res_d.inserted     = !any_hit && !full;
          res_d.dropped_full = !any_hit && full;
          res_d.purged_count = '0;
          count_d            = count_q + CW'(do_insert);
          res_d.live_count   = CountW'(count_d);
          state_d            = ST_DONE;
        end else if (tick) begin
          purge_d     = '0;
          sweep_cnt_d = '0;
          state_d     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        purge_d = purge_sum;
        if (!sweep_last) begin
          sweep_cnt_d = sweep_cnt_q + SW'(1);
        end
        if (sweep_end) begin
          count_d            = count_q - purge_sum;
          res_d.hit          = 1'b0;
          res_d.inserted     = 1'b0;
          res_d.dropped_full = 1'b0;
          res_d.purged_count = CountW'(purge_sum);
          res_d.live_count   = CountW'(count_d);
          state_d            = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      purge_q     <= '0;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      purge_q     <= purge_d;
      sweep_cnt_q <= sweep_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_compact_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !gap)
    else $error("table row has a hole while idle");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("live count differs from the number of valid cells");

  a_beat_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |=> (state_q == ST_DONE))
    else $error("heartbeat did not complete in one cycle");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({out_q.hit, out_q.inserted, out_q.dropped_full}) <= 1))
    else $error("more than one heartbeat outcome flagged");

endmodule

// ----- test/tb_peer_liveness_table_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for peer_liveness_table_top: heartbeat and tick words against
// an in-bench model of the address table, under several stale limits and idling mixes.
// Depends on plt_pkg and the peer_liveness_table_top RTL only.
module tb_peer_liveness_table_top;
  import plt_pkg::*;

  localparam int unsigned TableDepth    = 64;
  localparam int unsigned RegStaleLimit = 0;
  localparam logic [2:0]  StaleLimAddr  = 3'(4 * RegStaleLimit);
  localparam logic        CMD_BEAT      = 1'b0;
  localparam logic        CMD_TICK      = 1'b1;
  localparam int          WatchdogLimit = 3000;
  localparam int          MaxReports    = 50;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  plt_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  plt_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  peer_liveness_table_top #(.TABLE_DEPTH(TableDepth)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Model of the table and its register.
  plt_entry_t      peer_table[TableDepth];
  int              live_entries;
  logic [AgeW-1:0] stale_limit_model;

  plt_out_t table_result_q[$];

  int error_count;
  int idle_send_pct;
  int stall_recv_pct;
  int n_beats, n_ticks, n_hits, n_inserts, n_drops, n_purged, n_results;

  function automatic plt_out_t predict_liveness(input plt_in_t w);
    plt_out_t res;
    int       free_slot;
    int       purged;
    bit       found;
    res = '0;
    free_slot = -1;
    purged = 0;
    found = 1'b0;
    if (w.cmd == CMD_BEAT) begin
      n_beats++;
      for (int i = 0; i < TableDepth; i++) begin
        if (peer_table[i].valid) begin
          if (!found && peer_table[i].addr == w.peer_address) begin
            peer_table[i].age = '0;
            found = 1'b1;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (found) begin
        res.hit = 1'b1;
        n_hits++;
      end else if (free_slot >= 0) begin
        peer_table[free_slot].valid = 1'b1;
        peer_table[free_slot].addr  = w.peer_address;
        peer_table[free_slot].age   = '0;
        live_entries++;
        res.inserted = 1'b1;
        n_inserts++;
      end else begin
        res.dropped_full = 1'b1;
        n_drops++;
      end
    end else begin
      n_ticks++;
      for (int i = 0; i < TableDepth; i++) begin
        if (peer_table[i].valid) begin
          if (peer_table[i].age != AgeMax) peer_table[i].age = peer_table[i].age + 1'b1;
          if (peer_table[i].age >= stale_limit_model) begin
            peer_table[i].valid = 1'b0;
            purged++;
          end
        end
      end
      live_entries -= purged;
      n_purged += purged;
      res.purged_count = CountW'(purged);
    end
    res.live_count = CountW'(live_entries);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MaxReports) $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [CountW-1:0] got,
                             input logic [CountW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                n_results, name, got, want));
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: check each accepted word, then pick the ready for the next cycle.
  initial begin
    plt_out_t want;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (table_result_q.size() == 0) begin
          report_mismatch("result word arrived with nothing pending");
        end else begin
          want = table_result_q.pop_front();
          check_field("hit", CountW'(out_data_o.hit), CountW'(want.hit));
          check_field("inserted", CountW'(out_data_o.inserted), CountW'(want.inserted));
          check_field("dropped_full", CountW'(out_data_o.dropped_full),
                      CountW'(want.dropped_full));
          check_field("purged_count", out_data_o.purged_count, want.purged_count);
          check_field("live_count", out_data_o.live_count, want.live_count);
        end
        n_results++;
      end
      out_ready_i <= ($urandom_range(99) >= stall_recv_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
        else quiet++;
        if (quiet >= WatchdogLimit) begin
          $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, quiet);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic int sender_gap();
    int g;
    g = 0;
    while (g < 8 && $urandom_range(99) < idle_send_pct) g++;
    return g;
  endfunction

  task automatic send_word(input logic cmd, input logic [AddrW-1:0] address);
    plt_in_t w;
    int      gap;
    w.cmd = cmd;
    w.peer_address = address;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_result_q.push_back(predict_liveness(w));
  endtask

  // Hold the sender off until every pending result has been taken.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (table_result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_stale_limit(input logic [AgeW-1:0] value);
    pause_until_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= StaleLimAddr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stale_limit_model = value;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    idle_send_pct  = send_pct;
    stall_recv_pct = stall_pct;
  endtask

  // Heartbeats come in part from a pool of known peers so that hits, refreshes and a
  // full table all occur; the rest are ticks and fresh random addresses.
  task automatic run_traffic(input int n_items, input int tick_pct, input int fresh_pct,
                             input int pool_size, input bit drain_midway);
    logic [AddrW-1:0] pool[$];
    int               r;
    pool.push_back('0);
    pool.push_back('1);
    while (pool.size() < pool_size) pool.push_back($urandom);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (drain_midway && i == n_items / 2) pause_until_drained();
      if (r < tick_pct) send_word(CMD_TICK, $urandom);
      else if (r < tick_pct + fresh_pct) send_word(CMD_BEAT, $urandom);
      else send_word(CMD_BEAT, pool[$urandom_range(pool.size() - 1)]);
    end
  endtask

  task automatic test_directed_basics();
    set_idling(0, 0);
    send_word(CMD_BEAT, 32'h0000_0000);
    send_word(CMD_BEAT, 32'hFFFF_FFFF);
    send_word(CMD_BEAT, 32'h0000_0000);
    send_word(CMD_BEAT, 32'h8000_0001);
    send_word(CMD_TICK, 32'hDEAD_BEEF);
    write_stale_limit(16'd2);
    send_word(CMD_TICK, 32'h0000_0000);
    send_word(CMD_TICK, 32'hFFFF_FFFF);
    send_word(CMD_BEAT, 32'h1234_5678);
    send_word(CMD_TICK, 32'h0000_0000);
    send_word(CMD_BEAT, 32'h1234_5678);
    send_word(CMD_BEAT, 32'hEDCB_A987);
    send_word(CMD_TICK, 32'h0000_0000);
    send_word(CMD_TICK, 32'h0000_0000);
    write_stale_limit(16'd1);
    send_word(CMD_BEAT, 32'h5A5A_5A5A);
    send_word(CMD_BEAT, 32'hA5A5_A5A5);
    send_word(CMD_TICK, 32'h0000_0000);
    send_word(CMD_BEAT, 32'h5A5A_5A5A);
  endtask

  // Largest limit: nothing ages out, so the table fills and later peers are refused.
  task automatic test_fill_and_overflow();
    write_stale_limit(16'hFFFF);
    set_idling(0, 0);
    run_traffic(350, 5, 10, 90, 1'b0);
  endtask

  // Limit of one: every tick empties the table.
  task automatic test_purge_every_tick();
    write_stale_limit(16'd1);
    set_idling(66, 0);
    run_traffic(400, 20, 15, 40, 1'b0);
  endtask

  task automatic test_churn_under_stall();
    write_stale_limit(16'd12);
    set_idling(0, 66);
    run_traffic(400, 20, 10, 72, 1'b1);
  endtask

  task automatic test_mixed_idling();
    write_stale_limit(16'd3);
    set_idling(24, 24);
    run_traffic(400, 15, 15, 70, 1'b0);
  endtask

  task automatic test_default_limit();
    write_stale_limit(StaleLimRst);
    set_idling(0, 0);
    run_traffic(250, 10, 50, 60, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) peer_table[i] = '0;
    live_entries = 0;
    stale_limit_model = StaleLimRst;
    error_count = 0;
    n_beats = 0;
    n_ticks = 0;
    n_hits = 0;
    n_inserts = 0;
    n_drops = 0;
    n_purged = 0;
    n_results = 0;
    set_idling(0, 0);
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_fill_and_overflow();
    test_purge_every_tick();
    test_churn_under_stall();
    test_mixed_idling();
    test_default_limit();

    pause_until_drained();
    repeat (TableDepth + 8) @(posedge clk_i);
    if (table_result_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", table_result_q.size()));

    $display("Covered %0d heartbeats (%0d hits, %0d inserts, %0d refused when full)",
             n_beats, n_hits, n_inserts, n_drops);
    $display("and %0d ticks purging %0d entries; %0d results checked, %0d mismatches.",
             n_ticks, n_purged, n_results, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/plt_pkg.sv
src/plt_cell.sv
src/peer_liveness_table_top.sv
test/tb_peer_liveness_table_top.sv
